@@ src/tdp_pkg.sv @@
// Shared types and constants for the trial-division prime tester.
// Used by tdp_rem_unit, trial_division_prime_test and tb_top; depends on nothing.
package tdp_pkg;

  localparam int NUM_WIDTH_DEF = 16;

  // Width of a trial divisor: holds every d with d*d <= (2**w - 1), plus one step past it.
  function automatic int div_width(input int w);
    return (w + 1) / 2 + 1;
  endfunction

  typedef struct packed {
    logic done;      // one-cycle pulse: remainder is ready
    logic rem_zero;  // remainder is zero, valid with done
  } rem_status_t;

endpackage

@@ src/trial_division_prime_test.sv @@
// Trial-division primality tester, top level: sequencer around one shared remainder unit.
// Depends on tdp_pkg and tdp_rem_unit.
//
// A candidate is taken when start is high and busy is low; busy then stays high until the
// cycle in which the result is shown. The result appears for exactly one cycle with out_valid
// and cannot be held off. Divisors d = 2, 3, ... are tried while d*d <= candidate; d*d is kept
// by adding 2d+1 each step, and each remainder comes from the shared restoring unit at one bit
// a cycle.
module trial_division_prime_test #(
  parameter int NUM_WIDTH = tdp_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] in_candidate,
  output logic                 out_valid,
  output logic [NUM_WIDTH-1:0] out_number_tested,
  output logic                 out_is_prime
);
  import tdp_pkg::*;

  localparam int DW = div_width(NUM_WIDTH);
  localparam int SW = NUM_WIDTH + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [NUM_WIDTH-1:0] n_r, n_nxt;
  logic [DW-1:0]        d_r, d_nxt;
  logic [SW-1:0]        sq_r, sq_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_prime_r, out_prime_nxt;
  logic                 rem_go;
  rem_status_t          rem_st;

  tdp_rem_unit #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (rem_go),
    .dividend (n_r),
    .divisor  (d_r),
    .status   (rem_st)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    rem_go        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt     = in_candidate;
          d_nxt     = DW'(2);
          sq_nxt    = SW'(4);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_r < NUM_WIDTH'(2)) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (sq_r > {1'b0, n_r}) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rem_go    = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.rem_zero) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SW'({d_r, 1'b1});
            d_nxt     = d_r + DW'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_number_tested = n_r;
  assign out_is_prime      = out_prime_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE && $past(busy)))
    else $error("result word shown without a finished test");

  a_prime_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_prime) |-> (out_number_tested >= NUM_WIDTH'(2)))
    else $error("number below two reported prime");

  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && busy && !(sq_r > {1'b0, n_r}) && n_r >= NUM_WIDTH'(2))
      |=> state_r == ST_DIV)
    else $error("divisor within bound was not tried");

endmodule

@@ src/tdp_rem_unit.sv @@
// Restoring remainder unit: one dividend bit per cycle.
// Depends on tdp_pkg for the divisor width and the status struct.
module tdp_rem_unit #(
  parameter int NUM_WIDTH = tdp_pkg::NUM_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    go,
  input  logic [NUM_WIDTH-1:0]                    dividend,
  input  logic [tdp_pkg::div_width(NUM_WIDTH)-1:0] divisor,
  output tdp_pkg::rem_status_t                    status
);
  import tdp_pkg::*;

  localparam int DW = div_width(NUM_WIDTH);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [NUM_WIDTH-1:0] sh_r, sh_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW:0]       trial;
  logic [DW:0]       diff;

  assign trial = {rem_r, sh_r[NUM_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_WIDTH);
      sh_nxt   = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits DW bits.
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[DW-1:0];
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      sh_nxt  = {sh_r[NUM_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

  a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !busy_r) else $error("remainder unit started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> !busy_r) else $error("done raised while still busy");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !go && cnt_r == CW'(1)) |=> status.done)
    else $error("remainder unit missed its done pulse");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for trial_division_prime_test: a table of directed candidates, then
// shaped random candidates, each verdict checked against a typed verdict or a trial-division predictor.
// Depends on tdp_pkg and the trial_division_prime_test RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_WIDTH = tdp_pkg::NUM_WIDTH_DEF;
  localparam int RANDOM_WORDS = 120;
  localparam int CALM_TAIL = 20;
  localparam int DRAIN_POINT = 60;
  localparam int SETTLE_CYCLES = 64;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [NUM_WIDTH-1:0] number;
    logic                 prime;
  } verdict_t;

  typedef struct {
    logic [NUM_WIDTH-1:0] candidate;
    bit                   typed;
    logic                 prime;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [NUM_WIDTH-1:0] in_candidate;
  logic                 out_valid;
  logic [NUM_WIDTH-1:0] out_number_tested;
  logic                 out_is_prime;

  verdict_t awaited_verdicts[$];
  int       mismatch_count = 0;
  longint   cycle_count = 0;

  // Verdicts are typed in only for the small numbers and the field extremes.
  directed_row_t directed_rows[20] = '{
    '{16'd0,     1'b1, 1'b0},
    '{16'd1,     1'b1, 1'b0},
    '{16'd2,     1'b1, 1'b1},
    '{16'd3,     1'b1, 1'b1},
    '{16'd4,     1'b1, 1'b0},
    '{16'd65535, 1'b1, 1'b0},
    '{16'd65521, 1'b1, 1'b1},
    '{16'd32768, 1'b1, 1'b0},
    '{16'd5,     1'b0, 1'bx},
    '{16'd9,     1'b0, 1'bx},
    '{16'd25,    1'b0, 1'bx},
    '{16'd49,    1'b0, 1'bx},
    '{16'd121,   1'b0, 1'bx},
    '{16'd169,   1'b0, 1'bx},
    '{16'd257,   1'b0, 1'bx},
    '{16'd4093,  1'b0, 1'bx},
    '{16'h5555,  1'b0, 1'bx},
    '{16'hAAAA,  1'b0, 1'bx},
    '{16'd63001, 1'b0, 1'bx},
    '{16'd65025, 1'b0, 1'bx}
  };

  trial_division_prime_test #(
    .NUM_WIDTH(NUM_WIDTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_number_tested(out_number_tested),
    .out_is_prime     (out_is_prime)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic trial_division_verdict(input logic [NUM_WIDTH-1:0] n);
    longint divisor;
    if (n < 2) return 1'b0;
    for (divisor = 2; divisor * divisor <= n; divisor++) begin
      if (n % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // 45 in 100 candidates are drawn from 0 to 2047 so that the run stays short; squares sit right on the bound.
  function automatic logic [NUM_WIDTH-1:0] shaped_candidate();
    int pick;
    int root;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return NUM_WIDTH'($urandom_range(0, 2047));
    end else if (pick < 60) begin
      root = $urandom_range(2, 255);
      return NUM_WIDTH'(root * root);
    end else if (pick < 75) begin
      return NUM_WIDTH'($urandom_range(60000, 65535));
    end else begin
      return NUM_WIDTH'($urandom_range(0, 65535));
    end
  endfunction

  task automatic feed_candidate(input logic [NUM_WIDTH-1:0] value, input bit typed,
                                input logic typed_prime, input bit allow_gap);
    verdict_t verdict;
    int gap;
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_candidate <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdict.number = value;
    verdict.prime = typed ? typed_prime : trial_division_verdict(value);
    awaited_verdicts.push_back(verdict);
  endtask

  task automatic wait_for_verdicts();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    verdict_t oldest;
    if (rst_n && out_valid) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected word, number %0d is_prime %0b", $time, out_number_tested,
                 out_is_prime);
        mismatch_count++;
      end else begin
        oldest = awaited_verdicts.pop_front();
        if (out_number_tested !== oldest.number) begin
          $display("%0t: number_tested mismatch, expected %0d, actual %0d", $time,
                   oldest.number, out_number_tested);
          mismatch_count++;
        end
        if (out_is_prime !== oldest.prime) begin
          $display("%0t: is_prime mismatch for %0d, expected %0b, actual %0b", $time,
                   oldest.number, oldest.prime, out_is_prime);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, awaited_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_candidate <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      feed_candidate(directed_rows[i].candidate, directed_rows[i].typed,
                     directed_rows[i].prime, 1'b1);
    end
    wait_for_verdicts();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == DRAIN_POINT) wait_for_verdicts();
      feed_candidate(shaped_candidate(), 1'b0, 1'b0, i < RANDOM_WORDS - CALM_TAIL);
    end
    start <= 1'b0;

    while (awaited_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
